// ----- design/bbd_pkg.sv -----
`default_nettype none
package bbd_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int SHIFT_W    = BCD_W + VALUE_W;
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(CONV_CYCLES);
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] MAX_COUNT         = CNT_W'(MAX_DIGITS);
  localparam logic [STEP_W-1:0] LAST_STEP        = STEP_W'(CONV_CYCLES - 1);

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [CNT_W-1:0] n;
  } bbd_entry_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] dc);
    logic [CNT_W-1:0] n;
    n = dc;
    if (n == '0) n = CNT_W'(1);
    if (n > MAX_COUNT) n = MAX_COUNT;
    return n;
  endfunction

  function automatic logic [SHIFT_W-1:0] dd_step(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] t;
    t = s;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if (t[VALUE_W + j*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        t[VALUE_W + j*DIGIT_W +: DIGIT_W] = t[VALUE_W + j*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    return {t[SHIFT_W-2:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

// ----- design/bbd_ifs.sv -----
`default_nettype none
interface bbd_in_if;
  import bbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bbd_out_if;
  import bbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] bcd_digit;
  logic [CNT_W-1:0]   latch_index;
  logic               last_digit;
  modport source (output valid, output bcd_digit, output latch_index, output last_digit,
                  input ready);
  modport sink   (input valid, input bcd_digit, input latch_index, input last_digit,
                  output ready);
endinterface

interface bbd_cfg_if;
  import bbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/bbd_front.sv -----
`default_nettype none
module bbd_front (
  input  wire              clk,
  input  wire              rst_n,
  bbd_in_if.sink           in_chan,
  bbd_cfg_if.sink          cfg_chan,
  output logic             push_valid,
  input  wire              push_ready,
  output bbd_pkg::bbd_entry_t push_entry
);
  import bbd_pkg::*;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_DONE = 3'b100
  } cv_state_t;

  cv_state_t          cv_r, cv_nxt;
  logic [CNT_W-1:0]   digit_count_r;
  logic               hold_v_r, hold_v_nxt;
  logic [VALUE_W-1:0] hold_val_r;
  logic [CNT_W-1:0]   hold_n_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SHIFT_W-1:0] sh_r, sh_step;
  logic [CNT_W-1:0]   n_r;
  logic               in_hs, take;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !hold_v_r;
  assign in_hs          = in_chan.valid && !hold_v_r;
  assign take           = hold_v_r && (cv_r == CV_IDLE || (cv_r == CV_DONE && push_ready));

  assign push_valid     = (cv_r == CV_DONE);
  assign push_entry.bcd = sh_r[SHIFT_W-1 -: BCD_W];
  assign push_entry.n   = n_r;

  always_comb begin
    sh_step = sh_r;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      sh_step = dd_step(sh_step);
    end
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_hs) begin
      hold_v_nxt = 1'b1;
    end else if (take) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_comb begin
    cv_nxt   = cv_r;
    step_nxt = step_r;
    unique case (cv_r)
      CV_IDLE: begin
        if (take) begin
          cv_nxt   = CV_RUN;
          step_nxt = '0;
        end
      end
      CV_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) cv_nxt = CV_DONE;
      end
      CV_DONE: begin
        if (take) begin
          cv_nxt   = CV_RUN;
          step_nxt = '0;
        end else if (push_ready) begin
          cv_nxt = CV_IDLE;
        end
      end
      default: cv_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r          <= CV_IDLE;
      hold_v_r      <= 1'b0;
      step_r        <= '0;
      digit_count_r <= DIGIT_COUNT_RESET;
    end else begin
      cv_r     <= cv_nxt;
      hold_v_r <= hold_v_nxt;
      step_r   <= step_nxt;
      if (cfg_chan.valid) digit_count_r <= cfg_chan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      hold_val_r <= in_chan.value;
      hold_n_r   <= eff_count(digit_count_r);
    end
    if (take) begin
      sh_r <= {{BCD_W{1'b0}}, hold_val_r};
      n_r  <= hold_n_r;
    end else if (cv_r == CV_RUN) begin
      sh_r <= sh_step;
    end
  end

endmodule
`default_nettype wire

// ----- design/bbd_queue.sv -----
`default_nettype none
module bbd_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push_valid,
  output logic                push_ready,
  input  bbd_pkg::bbd_entry_t push_entry,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output bbd_pkg::bbd_entry_t pop_entry
);
  import bbd_pkg::*;

  bbd_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

// ----- design/bbd_back.sv -----
`default_nettype none
module bbd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 pop_valid,
  output logic                pop_ready,
  input  bbd_pkg::bbd_entry_t pop_entry,
  bbd_out_if.source           out_chan
);
  import bbd_pkg::*;

  logic             active_r;
  logic [BCD_W-1:0] bcd_r;
  logic [CNT_W-1:0] n_r, k_r, pos;
  logic             out_hs, last;

  assign last      = (k_r == n_r - CNT_W'(1));
  assign out_hs    = active_r && out_chan.ready;
  assign pop_ready = !active_r || (out_hs && last);
  assign pos       = n_r - CNT_W'(1) - k_r;

  assign out_chan.valid       = active_r;
  assign out_chan.bcd_digit   = bcd_r[{pos, 2'b00} +: DIGIT_W];
  assign out_chan.latch_index = k_r;
  assign out_chan.last_digit  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (pop_ready) begin
      active_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      bcd_r <= pop_entry.bcd;
      n_r   <= pop_entry.n;
      k_r   <= '0;
    end else if (out_hs && !last) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- design/binary_to_bcd_digit_display_driver.sv -----
// Channel    | Direction | Payload                              | Request moved
// in_chan    | sink      | value[31:0]                          | one value
// out_chan   | source    | bcd_digit, latch_index, last_digit   | one digit
// cfg_chan   | sink      | data[3:0] (digit_count)              | one register write
//
// A value is held, then converted four bits per cycle by the double-dabble
// shifter; a new value can be held while one converts. Digits leave the output
// sequencer one per cycle unless stalled, digit_count (1..10) per value.
// A two-entry queue parts converter and sequencer, so either side may stall.
// Synchronous active-low reset; digit_count resets to 3.
`default_nettype none
module binary_to_bcd_digit_display_driver (
  input  wire        clk,
  input  wire        rst_n,
  bbd_in_if.sink     in_chan,
  bbd_out_if.source  out_chan,
  bbd_cfg_if.sink    cfg_chan
);
  import bbd_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  bbd_entry_t push_entry, pop_entry;

  bbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  bbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

// ----- design/bbd_checker.sv -----
`default_nettype none
module bbd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] bcd_digit,
  input wire [3:0] latch_index,
  input wire       last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(bcd_digit) &&
      $stable(latch_index) && $stable(last_digit)))
    else $error("stalled digit request changed");

  a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_digit) |=>
      (out_valid && latch_index == $past(latch_index) + 4'd1))
    else $error("digit request out of sequence");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_digit) ##1 out_valid |-> (latch_index == 4'd0))
    else $error("new value does not start at latch 0");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bcd_digit <= 4'd9 && latch_index <= 4'd9))
    else $error("digit or latch index out of range");

endmodule

bind binary_to_bcd_digit_display_driver bbd_checker u_bbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .bcd_digit   (out_chan.bcd_digit),
  .latch_index (out_chan.latch_index),
  .last_digit  (out_chan.last_digit)
);
`default_nettype wire
